// File: rtl/core/cbm_pkg.sv
// Package for the cartridge bank mapper.
// Holds field widths, request and forward codes, register page codes and shared structs.
// No dependencies; every other file of the block depends on it.
package cbm_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned MapAddrW  = 19;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned PrgBankW  = 6;
  localparam int unsigned ChrBanks  = 8;
  localparam int unsigned ChrIdxW   = 3;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_CPU_MAP = 2'd1,
    REQ_PPU_MAP = 2'd2,
    REQ_NOP     = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    FWD_NONE     = 3'd0,
    FWD_SOUND    = 3'd1,
    FWD_IRQ_LAT  = 3'd2,
    FWD_IRQ_CTL  = 3'd3,
    FWD_IRQ_ACK  = 3'd4
  } fwd_kind_e;

  // Register pages, taken from address bits 15..12.
  localparam logic [3:0] PAGE_PRG16 = 4'h8;
  localparam logic [3:0] PAGE_SND0  = 4'h9;
  localparam logic [3:0] PAGE_SND1  = 4'hA;
  localparam logic [3:0] PAGE_SND2  = 4'hB;
  localparam logic [3:0] PAGE_PRG8  = 4'hC;
  localparam logic [3:0] PAGE_CHR0  = 4'hD;
  localparam logic [3:0] PAGE_CHR1  = 4'hE;
  localparam logic [3:0] PAGE_IRQ   = 4'hF;

  localparam logic [1:0] LO_MIRROR  = 2'd3;
  localparam logic [1:0] LO_IRQ_NONE = 2'd3;

  localparam logic [PrgBankW-1:0] PRG_FIXED_BANK = 6'd63;

  localparam logic [CfgIdxW-1:0] CFG_A0_MASK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_A1_MASK = 2'd1;

  localparam logic [CfgDataW-1:0] A0_MASK_RESET = 16'h0001;
  localparam logic [CfgDataW-1:0] A1_MASK_RESET = 16'h0002;

  typedef struct packed {
    req_type_e         req_type;
    logic [AddrW-1:0]  bus_address;
    logic [DataW-1:0]  write_data;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [MapAddrW-1:0]  mapped_address;
    logic [1:0]           mirror_mode;
    fwd_kind_e            forward_kind;
    logic [AddrW-1:0]     forward_address;
    logic [DataW-1:0]     forward_data;
  } rsp_t;

  typedef struct packed {
    logic               prg16_we;
    logic               prg8_we;
    logic               chr_we;
    logic [ChrIdxW-1:0] chr_idx;
    logic               mirror_we;
    logic [DataW-1:0]   data;
  } upd_t;

endpackage

// File: rtl/core/cbm_if.sv
// Channel interfaces of the cartridge bank mapper: request, result and configuration.
// Depends on cbm_pkg for the payload widths and types.
interface cbm_req_if;
  logic                       valid;
  logic                       ready;
  cbm_pkg::req_type_e         req_type;
  logic [cbm_pkg::AddrW-1:0]  bus_address;
  logic [cbm_pkg::DataW-1:0]  write_data;

  modport source (output valid, req_type, bus_address, write_data, input ready);
  modport sink   (input valid, req_type, bus_address, write_data, output ready);
endinterface

interface cbm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [cbm_pkg::MapAddrW-1:0]  mapped_address;
  logic [1:0]                    mirror_mode;
  cbm_pkg::fwd_kind_e            forward_kind;
  logic [cbm_pkg::AddrW-1:0]     forward_address;
  logic [cbm_pkg::DataW-1:0]     forward_data;

  modport source (output valid, hit, mapped_address, mirror_mode, forward_kind,
                  forward_address, forward_data, input ready);
  modport sink   (input valid, hit, mapped_address, mirror_mode, forward_kind,
                  forward_address, forward_data, output ready);
endinterface

interface cbm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cbm_pkg::CfgIdxW-1:0]   index;
  logic [cbm_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/cbm_bank_regs.sv
// Bank state of the mapper: line masks, program banks, character banks and mirroring.
// Depends on cbm_pkg; updated by the decode results committed in the top level.
module cbm_bank_regs (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [cbm_pkg::CfgIdxW-1:0]                   cfg_idx_i,
  input  logic [cbm_pkg::CfgDataW-1:0]                  cfg_data_i,
  input  cbm_pkg::upd_t                                 upd_i,
  output logic [cbm_pkg::CfgDataW-1:0]                  a0_mask_o,
  output logic [cbm_pkg::CfgDataW-1:0]                  a1_mask_o,
  output logic [cbm_pkg::DataW-1:0]                     prg16_o,
  output logic [cbm_pkg::DataW-1:0]                     prg8_o,
  output logic [cbm_pkg::ChrBanks-1:0][cbm_pkg::DataW-1:0] chr_o,
  output logic [1:0]                                    mirror_o
);
  import cbm_pkg::*;

  logic [CfgDataW-1:0]               a0_mask_q, a1_mask_q;
  logic [DataW-1:0]                  prg16_q, prg8_q;
  logic [ChrBanks-1:0][DataW-1:0]    chr_q;
  logic [1:0]                        mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_mask_q <= A0_MASK_RESET;
      a1_mask_q <= A1_MASK_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_A0_MASK) begin
        a0_mask_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_A1_MASK) begin
        a1_mask_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg16_q  <= '0;
      prg8_q   <= DataW'(1);
      mirror_q <= '0;
      for (int i = 0; i < ChrBanks; i++) begin
        chr_q[i] <= DataW'(i);
      end
    end else begin
      if (upd_i.prg16_we) begin
        prg16_q <= upd_i.data;
      end
      if (upd_i.prg8_we) begin
        prg8_q <= upd_i.data;
      end
      if (upd_i.chr_we) begin
        chr_q[upd_i.chr_idx] <= upd_i.data;
      end
      if (upd_i.mirror_we) begin
        mirror_q <= upd_i.data[3:2];
      end
    end
  end

  assign a0_mask_o = a0_mask_q;
  assign a1_mask_o = a1_mask_q;
  assign prg16_o   = prg16_q;
  assign prg8_o    = prg8_q;
  assign chr_o     = chr_q;
  assign mirror_o  = mirror_q;

endmodule

// File: rtl/core/cbm_decode.sv
// Request decode of the mapper: register address rebuild, write decode and translation.
// Depends on cbm_pkg; pure combinational logic between the request and result registers.
module cbm_decode (
  input  logic                                          en_i,
  input  cbm_pkg::req_t                                 req_i,
  input  logic [cbm_pkg::CfgDataW-1:0]                  a0_mask_i,
  input  logic [cbm_pkg::CfgDataW-1:0]                  a1_mask_i,
  input  logic [cbm_pkg::DataW-1:0]                     prg16_i,
  input  logic [cbm_pkg::DataW-1:0]                     prg8_i,
  input  logic [cbm_pkg::ChrBanks-1:0][cbm_pkg::DataW-1:0] chr_i,
  input  logic [1:0]                                    mirror_i,
  output cbm_pkg::rsp_t                                 rsp_o,
  output cbm_pkg::upd_t                                 upd_o
);
  import cbm_pkg::*;

  logic [AddrW-1:0]     a;
  logic [AddrW-1:0]     reg_addr;
  logic [3:0]           page;
  logic [1:0]           lo;
  logic                 is_wr;
  logic [PrgBankW-1:0]  prg_bank;
  logic [DataW-1:0]     chr_bank;
  fwd_kind_e            fkind;
  upd_t                 upd;

  assign a        = req_i.bus_address;
  assign lo       = {|(a & a1_mask_i), |(a & a0_mask_i)};
  assign page     = a[15:12];
  assign reg_addr = {page, 10'd0, lo};
  assign is_wr    = (req_i.req_type == REQ_WRITE) && a[15];

  always_comb begin
    fkind        = FWD_NONE;
    upd          = '0;
    upd.data     = req_i.write_data;
    upd.chr_idx  = {1'b0, lo};
    if (is_wr) begin
      unique case (page)
        PAGE_PRG16: upd.prg16_we = 1'b1;
        PAGE_SND0, PAGE_SND1: fkind = FWD_SOUND;
        PAGE_SND2: begin
          if (lo == LO_MIRROR) begin
            upd.mirror_we = 1'b1;
          end else begin
            fkind = FWD_SOUND;
          end
        end
        PAGE_PRG8: upd.prg8_we = 1'b1;
        PAGE_CHR0: upd.chr_we = 1'b1;
        PAGE_CHR1: begin
          upd.chr_we  = 1'b1;
          upd.chr_idx = {1'b1, lo};
        end
        PAGE_IRQ: begin
          unique case (lo)
            2'd0:        fkind = FWD_IRQ_LAT;
            2'd1:        fkind = FWD_IRQ_CTL;
            2'd2:        fkind = FWD_IRQ_ACK;
            LO_IRQ_NONE: fkind = FWD_NONE;
            default:     fkind = FWD_NONE;
          endcase
        end
        default: fkind = FWD_NONE;
      endcase
    end
    upd.prg16_we  = upd.prg16_we & en_i;
    upd.prg8_we   = upd.prg8_we & en_i;
    upd.chr_we    = upd.chr_we & en_i;
    upd.mirror_we = upd.mirror_we & en_i;
  end

  always_comb begin
    unique case (a[14:13])
      2'd0:    prg_bank = {prg16_i[PrgBankW-2:0], 1'b0};
      2'd1:    prg_bank = {prg16_i[PrgBankW-2:0], 1'b1};
      2'd2:    prg_bank = prg8_i[PrgBankW-1:0];
      default: prg_bank = PRG_FIXED_BANK;
    endcase
  end

  assign chr_bank = chr_i[a[12:10]];

  always_comb begin
    rsp_o                 = '0;
    rsp_o.forward_kind    = fkind;
    rsp_o.mirror_mode     = (is_wr && page == PAGE_SND2 && lo == LO_MIRROR)
                            ? req_i.write_data[3:2] : mirror_i;
    if (fkind != FWD_NONE) begin
      rsp_o.forward_address = reg_addr;
      rsp_o.forward_data    = req_i.write_data;
    end
    unique case (req_i.req_type)
      REQ_CPU_MAP: begin
        if (a[15]) begin
          rsp_o.hit            = 1'b1;
          rsp_o.mapped_address = {prg_bank, a[12:0]};
        end
      end
      REQ_PPU_MAP: begin
        if (a[15:13] == 3'd0) begin
          rsp_o.hit            = 1'b1;
          rsp_o.mapped_address = {1'b0, chr_bank, a[9:0]};
        end
      end
      REQ_WRITE, REQ_NOP: rsp_o.hit = 1'b0;
      default: rsp_o.hit = 1'b0;
    endcase
  end

  assign upd_o = upd;

endmodule

// File: rtl/core/cartridge_bank_mapper_unit.sv
// Cartridge bank mapper with bank registers and CPU and PPU address translation.
// Channels: req_i takes one bus request per word (register write, CPU translate or
// PPU translate); rsp_o returns exactly one result word per request; cfg_i writes the
// two address line masks, index 0 for line A0 and index 1 for line A1.
// A request is held in an input register; the decode, bank update and translation
// all happen on the path from that register to the result register.
// A new word is taken every cycle while the output register can drain, so a sustained
// rate of one word per cycle is reached.
// A result that waits on rsp_o.ready stays in the output register while one more
// request may enter the input register; only when both are full is req_i.ready low.
// Bank state changes when the write leaves the input register, so a request that
// follows a write sees the new banks.
// Reset clears the pipeline and sets the masks to 1 and 2, the 16K program bank to 0,
// the 8K program bank to 1, character bank i to i and the mirroring mode to 0.
// The configuration port is always ready and should only be written when idle.
// Depends on cbm_pkg, cbm_if, cbm_bank_regs and cbm_decode.
module cartridge_bank_mapper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbm_req_if.sink    req_i,
  cbm_rsp_if.source  rsp_o,
  cbm_cfg_if.sink    cfg_i
);
  import cbm_pkg::*;

  req_t                        req_q;
  logic                        req_valid_q, req_valid_d;
  rsp_t                        rsp_q, rsp_d;
  logic                        rsp_valid_q, rsp_valid_d;
  logic                        advance;
  logic                        accept;
  upd_t                        upd;
  logic [CfgDataW-1:0]         a0_mask, a1_mask;
  logic [DataW-1:0]            prg16, prg8;
  logic [ChrBanks-1:0][DataW-1:0] chr;
  logic [1:0]                  mirror;

  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign req_valid_d = accept ? 1'b1 : (advance ? 1'b0 : req_valid_q);
  assign rsp_valid_d = advance ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.req_type    <= req_i.req_type;
      req_q.bus_address <= req_i.bus_address;
      req_q.write_data  <= req_i.write_data;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  cbm_bank_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .upd_i      (upd),
    .a0_mask_o  (a0_mask),
    .a1_mask_o  (a1_mask),
    .prg16_o    (prg16),
    .prg8_o     (prg8),
    .chr_o      (chr),
    .mirror_o   (mirror)
  );

  cbm_decode u_decode (
    .en_i      (advance),
    .req_i     (req_q),
    .a0_mask_i (a0_mask),
    .a1_mask_i (a1_mask),
    .prg16_i   (prg16),
    .prg8_i    (prg8),
    .chr_i     (chr),
    .mirror_i  (mirror),
    .rsp_o     (rsp_d),
    .upd_o     (upd)
  );

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.hit             = rsp_q.hit;
  assign rsp_o.mapped_address  = rsp_q.mapped_address;
  assign rsp_o.mirror_mode     = rsp_q.mirror_mode;
  assign rsp_o.forward_kind    = rsp_q.forward_kind;
  assign rsp_o.forward_address = rsp_q.forward_address;
  assign rsp_o.forward_data    = rsp_q.forward_data;

endmodule
